// File: rtl/chc_pkg.sv
// Shared widths, pipeline word type and arctangent table for the compass heading unit.
`default_nettype none

package chc_pkg;

  localparam int unsigned CORDIC_STAGES = 16;  // micro-rotations, 8..24
  localparam int unsigned ATAN_LEN      = 24;
  localparam int unsigned SHW           = $clog2(ATAN_LEN);

  localparam int unsigned IN_W  = 16;
  localparam int unsigned VEC_W = 44;  // reading * 2^24 plus CORDIC gain
  localparam int unsigned ANG_W = 26;  // signed degrees, 16 fractional bits
  localparam int unsigned FRAC  = 16;
  localparam int unsigned HD_W  = 9;

  localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 * 65536);

  typedef struct packed {
    logic signed [VEC_W-1:0] a;
    logic signed [VEC_W-1:0] b;
    logic signed [ANG_W-1:0] z;
    logic                    special;     // heading already known
    logic [HD_W-1:0]         sp_heading;
    logic                    x_pos;
  } cordic_t;

  // atan(2^-i) in degrees, 16 fractional bits, rounded
  function automatic logic [ANG_W-1:0] atan_q16(input logic [SHW-1:0] idx);
    logic [ANG_W-1:0] r;
    case (idx)
      SHW'(0):  r = ANG_W'(2949120);
      SHW'(1):  r = ANG_W'(1740967);
      SHW'(2):  r = ANG_W'(919879);
      SHW'(3):  r = ANG_W'(466945);
      SHW'(4):  r = ANG_W'(234379);
      SHW'(5):  r = ANG_W'(117304);
      SHW'(6):  r = ANG_W'(58666);
      SHW'(7):  r = ANG_W'(29335);
      SHW'(8):  r = ANG_W'(14668);
      SHW'(9):  r = ANG_W'(7334);
      SHW'(10): r = ANG_W'(3667);
      SHW'(11): r = ANG_W'(1833);
      SHW'(12): r = ANG_W'(917);
      SHW'(13): r = ANG_W'(458);
      SHW'(14): r = ANG_W'(229);
      SHW'(15): r = ANG_W'(115);
      SHW'(16): r = ANG_W'(57);
      SHW'(17): r = ANG_W'(29);
      SHW'(18): r = ANG_W'(14);
      SHW'(19): r = ANG_W'(7);
      SHW'(20): r = ANG_W'(4);
      SHW'(21): r = ANG_W'(2);
      SHW'(22): r = ANG_W'(1);
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/chc_stage.sv
// One registered vectoring CORDIC micro-rotation stage.
`default_nettype none

module chc_stage
  import chc_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic [SHW-1:0] shift_i,
  input  wire logic           vld_i,
  input  wire cordic_t        data_i,
  output logic                vld_o,
  output cordic_t             data_o
);

  logic    vld_q;
  cordic_t data_d, data_q;
  logic signed [VEC_W-1:0] da, db;
  logic signed [ANG_W-1:0] dz;

  always_comb begin
    da     = data_i.b >>> shift_i;
    db     = data_i.a >>> shift_i;
    dz     = $signed(atan_q16(shift_i));
    data_d = data_i;
    // rotate toward the abscissa
    if (!data_i.b[VEC_W-1]) begin
      data_d.a = data_i.a + da;
      data_d.b = data_i.b - db;
      data_d.z = data_i.z + dz;
    end else begin
      data_d.a = data_i.a - da;
      data_d.b = data_i.b + db;
      data_d.z = data_i.z - dz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && vld_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

// File: rtl/compass_heading_atan2_unit.sv
// Top level: pipelined CORDIC that turns a magnetometer x/y pair into a heading in degrees.
`default_nettype none

// Takes one word (mag_x, mag_y) per cycle and returns heading_deg = atan2(x, y) in
// degrees plus 180, truncated, range 0..360. The pipeline is an entry register
// with the half-plane pre-rotation and the exact-answer cases, one register per
// micro-rotation, and the output register. Throughput is one word per cycle; a
// stalled output only holds the pipeline back once every stage behind it is full,
// empty stages keep filling.
module compass_heading_atan2_unit
  import chc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic signed [IN_W-1:0] mag_x_i,
  input  wire logic signed [IN_W-1:0] mag_y_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [HD_W-1:0]             heading_deg_o
);

  localparam int unsigned N = CORDIC_STAGES;

  localparam logic [HD_W-1:0] HD_45  = HD_W'(45);
  localparam logic [HD_W-1:0] HD_90  = HD_W'(90);
  localparam logic [HD_W-1:0] HD_135 = HD_W'(135);
  localparam logic [HD_W-1:0] HD_180 = HD_W'(180);
  localparam logic [HD_W-1:0] HD_225 = HD_W'(225);
  localparam logic [HD_W-1:0] HD_270 = HD_W'(270);
  localparam logic [HD_W-1:0] HD_315 = HD_W'(315);
  localparam logic [HD_W-1:0] HD_359 = HD_W'(359);
  localparam logic [HD_W-1:0] HD_360 = HD_W'(360);
  localparam logic [HD_W-1:0] HD_179 = HD_W'(179);

  logic [N+1:0] rdy;
  logic [N:0]   vld;
  cordic_t      pipe [N+1];

  // ---------------- entry stage ----------------
  cordic_t   entry_d, entry_q;
  logic      entry_vld_q;
  logic      x_zero, y_zero, x_neg, y_neg, diag;
  logic [IN_W:0] abs_x, abs_y;

  always_comb begin
    x_zero = (mag_x_i == '0);
    y_zero = (mag_y_i == '0);
    x_neg  = mag_x_i[IN_W-1];
    y_neg  = mag_y_i[IN_W-1];
    abs_x  = x_neg ? -{mag_x_i[IN_W-1], mag_x_i} : {mag_x_i[IN_W-1], mag_x_i};
    abs_y  = y_neg ? -{mag_y_i[IN_W-1], mag_y_i} : {mag_y_i[IN_W-1], mag_y_i};
    diag   = (abs_x == abs_y);

    entry_d.x_pos   = !x_neg && !x_zero;
    entry_d.special = x_zero || y_zero || diag;
    if (x_zero) begin
      entry_d.sp_heading = y_neg ? HD_360 : HD_180;
    end else if (y_zero) begin
      entry_d.sp_heading = x_neg ? HD_90 : HD_270;
    end else if (!y_neg) begin
      entry_d.sp_heading = x_neg ? HD_135 : HD_225;
    end else begin
      entry_d.sp_heading = x_neg ? HD_45 : HD_315;
    end

    // abscissa is y, ordinate is x, both scaled by 2^24
    entry_d.a = {{(VEC_W-IN_W-24){mag_y_i[IN_W-1]}}, mag_y_i, 24'b0};
    entry_d.b = {{(VEC_W-IN_W-24){mag_x_i[IN_W-1]}}, mag_x_i, 24'b0};
    entry_d.z = '0;
    if (y_neg) begin
      // left half plane: rotate by 180 degrees first
      entry_d.z = x_neg ? -ANG_180 : ANG_180;
      entry_d.a = -entry_d.a;
      entry_d.b = -entry_d.b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= 1'b0;
    end else if (rdy[0]) begin
      entry_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      entry_q <= entry_d;
    end
  end

  assign vld[0]  = entry_vld_q;
  assign pipe[0] = entry_q;

  // ---------------- micro-rotations ----------------
  for (genvar k = 0; k < N; k++) begin : g_stage
    chc_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (rdy[k+1]),
      .shift_i (SHW'(k)),
      .vld_i   (vld[k]),
      .data_i  (pipe[k]),
      .vld_o   (vld[k+1]),
      .data_o  (pipe[k+1])
    );
  end

  // a register loads when it is empty or its word moves on
  for (genvar k = 0; k <= N; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  // ---------------- output stage ----------------
  logic                   out_vld_q;
  logic [HD_W-1:0]        heading_d, heading_q;
  logic signed [ANG_W:0]  h_sum;
  logic [ANG_W-FRAC-1:0]  h_deg;
  cordic_t                fin;

  always_comb begin
    fin   = pipe[N];
    h_sum = {fin.z[ANG_W-1], fin.z} + {1'b0, ANG_180};
    h_deg = h_sum[ANG_W] ? '0 : h_sum[ANG_W-1:FRAC];
    if (fin.special) begin
      heading_d = fin.sp_heading;
    end else if (fin.x_pos) begin
      if (h_deg < (ANG_W-FRAC)'(HD_180)) begin
        heading_d = HD_180;
      end else if (h_deg > (ANG_W-FRAC)'(HD_359)) begin
        heading_d = HD_359;
      end else begin
        heading_d = h_deg[HD_W-1:0];
      end
    end else begin
      heading_d = (h_deg > (ANG_W-FRAC)'(HD_179)) ? HD_179 : h_deg[HD_W-1:0];
    end
  end

  assign rdy[N+1] = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rdy[N+1]) begin
      out_vld_q <= vld[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[N+1] && vld[N]) begin
      heading_q <= heading_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign heading_deg_o = heading_q;
  assign in_stall_o    = !rdy[0];

  // ---------------- checks ----------------
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (heading_q <= HD_360))
    else $error("heading out of range");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> entry_vld_q)
    else $error("accepted word lost at entry");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&vld) && out_vld_q && out_stall_i) |-> in_stall_o)
    else $error("full pipeline accepted a word");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&vld) && out_vld_q && out_stall_i))
    else $error("stall raised with room in the pipeline");

endmodule

`default_nettype wire
